/* sv/swcc_pkg.sv */
// Package for the swept circle collision time block.
// Shared widths, the window reset value and the width helper; no dependencies.
package swcc_pkg;

    localparam int RADIUS_W = 16;
    localparam int TIME_W = 24;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 24'h010000;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [RADIUS_W-1:0] t_radius;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* sv/swcc_if.sv */
// Channel interfaces of the swept circle collision time block.
// Depends on swcc_pkg for the radius and time types.
interface swcc_in_if import swcc_pkg::*; #(parameter int COORD_WIDTH = 24) ();
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    t_radius first_radius;
    logic signed [COORD_WIDTH-1:0] first_vx;
    logic signed [COORD_WIDTH-1:0] first_vy;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    t_radius second_radius;
    logic signed [COORD_WIDTH-1:0] second_vx;
    logic signed [COORD_WIDTH-1:0] second_vy;

    modport source(output valid, first_x, first_y, first_radius, first_vx, first_vy,
                   second_x, second_y, second_radius, second_vx, second_vy,
                   input ready);
    modport sink(input valid, first_x, first_y, first_radius, first_vx, first_vy,
                 second_x, second_y, second_radius, second_vx, second_vy,
                 output ready);
endinterface

interface swcc_out_if import swcc_pkg::*; ();
    logic valid;
    logic ready;
    logic hit;
    t_time impact_time;

    modport source(output valid, hit, impact_time, input ready);
    modport sink(input valid, hit, impact_time, output ready);
endinterface

/* sv/swept_circle_collision_time.sv */
// Top level of the swept circle collision time block.
// Uses swcc_pkg, swcc_if, swcc_wmul, swcc_sqrt and swcc_div.
//
//  port      dir  handshake     payload
//  i_pkt     in   valid/ready   two circles: centre, radius, velocity
//  o_res     out  valid/ready   hit flag, impact time Q8.16
//  i_cfg_*   in   write enable  time window Q8.16
//
// One item per cycle while the skid register is empty. Most of the pipeline lies in
// the one-bit-per-stage square root and the 24-stage divider.
// Reset is synchronous, active low; it clears valid bits and sets the window to 1.0.
// A stall on o_res parks one item in a skid register; the pipeline halts when it is full.
module swept_circle_collision_time import swcc_pkg::*; #(
    parameter int COORD_WIDTH = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    swcc_in_if.sink          i_pkt,
    swcc_out_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic [TIME_W-1:0] i_cfg_wdata
);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int OW  = max_int(DW, RADIUS_W + 2);
    localparam int PW  = 2 * OW;
    localparam int SW  = 2 * OW + 1;
    localparam int AW  = 2 * OW;
    localparam int RW  = 2 * OW;
    localparam int MW  = 2 * SW;
    localparam int TW  = SW + 1;
    localparam int QW  = AW + TIME_W;
    localparam int XW  = max_int(TW - 1 + TIME_FRAC_BITS, QW);
    localparam int SBW = 1 + AW + SW + QW;
    localparam int MUL_LAT = 4;

    logic en;
    t_time r_window;

    // stage 1: differences
    logic r1_v;
    logic signed [OW-1:0] r1_dx, r1_dy, r1_wx, r1_wy, r1_rs;
    // stage 2: products
    logic r2_v;
    logic signed [PW-1:0] r2_dxwx, r2_dywy, r2_wxwx, r2_wywy, r2_dxdx, r2_dydy, r2_rsrs;
    // stage 3: quadratic coefficients
    logic r3_v;
    logic signed [SW-1:0] r3_a, r3_h, r3_c;
    // wide product delay line
    logic r_dv [MUL_LAT];
    logic signed [SW-1:0] r_da [MUL_LAT];
    logic signed [SW-1:0] r_dh [MUL_LAT];
    logic signed [MW-1:0] hh, ac, wa;
    // stage 8: discriminant
    logic r8_v;
    logic signed [MW-1:0] r8_d;
    logic signed [SW-1:0] r8_a, r8_h;
    logic [QW-1:0] r8_wa;

    logic [2*RW-1:0] sq_rad;
    logic [SBW-1:0] sq_in_side, sq_side;
    logic sq_v;
    logic [RW-1:0] sq_root;
    logic sq_miss;
    logic [AW-1:0] sq_a;
    logic signed [SW-1:0] sq_h;
    logic [QW-1:0] sq_wa;

    logic r_p1_v, r_p1_miss;
    logic signed [TW-1:0] r_p1_tmin;
    logic [AW-1:0] r_p1_a;
    logic [QW-1:0] r_p1_wa;
    logic signed [TW-1:0] n_tmin, n_tmax;

    logic r_p2_v, r_p2_hit;
    logic [QW-1:0] r_p2_num;
    logic [AW-1:0] r_p2_a;
    logic pos;
    logic [XW-1:0] scaled;
    logic over, n_hit;

    logic dv_v, dv_hit;
    t_time dv_quo;

    logic r_ov, r_sv;
    logic r_oh, r_sh;
    t_time r_ot, r_st;
    logic n_pend_hit;
    t_time n_pend_time;

    assign en = !r_sv;
    assign i_pkt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r8_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            for (int i = 0; i < MUL_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r1_v <= i_pkt.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_dv[0] <= r3_v;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r8_v <= r_dv[MUL_LAT-1];
            r_p1_v <= sq_v;
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= OW'(DW'(i_pkt.second_x) - DW'(i_pkt.first_x));
            r1_dy <= OW'(DW'(i_pkt.second_y) - DW'(i_pkt.first_y));
            r1_wx <= OW'(DW'(i_pkt.second_vx) - DW'(i_pkt.first_vx));
            r1_wy <= OW'(DW'(i_pkt.second_vy) - DW'(i_pkt.first_vy));
            r1_rs <= $signed(OW'((RADIUS_W+1)'(i_pkt.first_radius)
                                 + (RADIUS_W+1)'(i_pkt.second_radius)));

            r2_dxwx <= PW'(r1_dx * r1_wx);
            r2_dywy <= PW'(r1_dy * r1_wy);
            r2_wxwx <= PW'(r1_wx * r1_wx);
            r2_wywy <= PW'(r1_wy * r1_wy);
            r2_dxdx <= PW'(r1_dx * r1_dx);
            r2_dydy <= PW'(r1_dy * r1_dy);
            r2_rsrs <= PW'(r1_rs * r1_rs);

            r3_a <= SW'(r2_wxwx) + SW'(r2_wywy);
            r3_h <= SW'(r2_dxwx) + SW'(r2_dywy);
            r3_c <= SW'(r2_dxdx) + SW'(r2_dydy) - SW'(r2_rsrs);

            r_da[0] <= r3_a;
            r_dh[0] <= r3_h;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_da[i] <= r_da[i-1];
                r_dh[i] <= r_dh[i-1];
            end

            r8_d  <= hh - ac;
            r8_a  <= r_da[MUL_LAT-1];
            r8_h  <= r_dh[MUL_LAT-1];
            r8_wa <= wa[QW-1:0];
        end
    end

    swcc_wmul #(.N(SW)) u_hh (
        .i_clk(i_clk), .i_en(en), .i_a(r3_h), .i_b(r3_h), .o_p(hh)
    );
    swcc_wmul #(.N(SW)) u_ac (
        .i_clk(i_clk), .i_en(en), .i_a(r3_a), .i_b(r3_c), .o_p(ac)
    );
    swcc_wmul #(.N(SW)) u_wa (
        .i_clk(i_clk), .i_en(en), .i_a($signed(SW'(r_window))), .i_b(r3_a), .o_p(wa)
    );

    // no relative motion or negative discriminant: miss, root of zero
    assign sq_rad = r8_d[MW-1] ? '0 : r8_d[2*RW-1:0];
    assign sq_in_side = {(r8_a == '0) || r8_d[MW-1], r8_a[AW-1:0], r8_h, r8_wa};

    swcc_sqrt #(.RW(RW), .SBW(SBW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r8_v),
        .i_rad(sq_rad), .i_side(sq_in_side),
        .o_valid(sq_v), .o_root(sq_root), .o_side(sq_side)
    );

    assign {sq_miss, sq_a, sq_h, sq_wa} = sq_side;
    assign n_tmin = -TW'(sq_h) - $signed(TW'(sq_root));
    assign n_tmax = $signed(TW'(sq_root)) - TW'(sq_h);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_tmin <= n_tmin;
            r_p1_miss <= sq_miss || n_tmax[TW-1];
            r_p1_a    <= sq_a;
            r_p1_wa   <= sq_wa;
        end
    end

    // first contact after the window end: miss
    assign pos    = !r_p1_tmin[TW-1] && (r_p1_tmin != '0);
    assign scaled = XW'(r_p1_tmin[TW-2:0]) << TIME_FRAC_BITS;
    assign over   = pos && (scaled > XW'(r_p1_wa));
    assign n_hit  = !r_p1_miss && !over;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_hit <= n_hit;
            r_p2_num <= (n_hit && pos) ? scaled[QW-1:0] : '0;
            r_p2_a   <= r_p1_a;
        end
    end

    swcc_div #(.AW(AW), .QB(TIME_W), .SBW(1)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_p2_v),
        .i_num(r_p2_num), .i_den(r_p2_a), .i_side(r_p2_hit),
        .o_valid(dv_v), .o_quo(dv_quo), .o_side(dv_hit)
    );

    assign n_pend_hit  = dv_hit;
    assign n_pend_time = dv_hit ? dv_quo : '0;

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (o_res.ready) begin
                r_sv <= 1'b0;
            end
        end else if (!r_ov || o_res.ready) begin
            r_ov <= dv_v;
        end else if (dv_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (o_res.ready) begin
                r_oh <= r_sh;
                r_ot <= r_st;
            end
        end else if (!r_ov || o_res.ready) begin
            r_oh <= n_pend_hit;
            r_ot <= n_pend_time;
        end else begin
            r_sh <= n_pend_hit;
            r_st <= n_pend_time;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.hit         = r_oh;
    assign o_res.impact_time = r_ot;

`ifndef NO_ASSERTIONS
    a_miss_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> o_res.impact_time == '0)
        else $error("miss carries a nonzero impact time");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid register full while output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !o_res.ready && dv_v))
        else $error("skid register filled without a stalled output");

    a_time_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.hit |-> o_res.impact_time <= r_window)
        else $error("impact time beyond the window");
`endif
endmodule

/* sv/swcc_wmul.sv */
// Four-stage signed multiplier for operands above the native multiplier size.
// Splits magnitudes into halves; depends on swcc_pkg only by convention.
module swcc_wmul import swcc_pkg::*; #(
    parameter int N = 51
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [N-1:0]   i_a,
    input  logic signed [N-1:0]   i_b,
    output logic signed [2*N-1:0] o_p
);
    localparam int L = (N + 1) / 2;
    localparam int HW = N - L;

    logic [N-1:0] r_ma, r_mb;
    logic r_neg1, r_neg2, r_neg3;
    logic [2*L-1:0] r_ll;
    logic [L+HW-1:0] r_lh, r_hl;
    logic [2*HW-1:0] r_hh;
    logic [2*N-1:0] r_sum;
    logic signed [2*N-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= i_a[N-1] ? N'(-i_a) : N'(i_a);
            r_mb   <= i_b[N-1] ? N'(-i_b) : N'(i_b);
            r_neg1 <= i_a[N-1] ^ i_b[N-1];
            r_ll   <= (2*L)'(r_ma[L-1:0]) * (2*L)'(r_mb[L-1:0]);
            r_lh   <= (L+HW)'(r_ma[L-1:0]) * (L+HW)'(r_mb[N-1:L]);
            r_hl   <= (L+HW)'(r_ma[N-1:L]) * (L+HW)'(r_mb[L-1:0]);
            r_hh   <= (2*HW)'(r_ma[N-1:L]) * (2*HW)'(r_mb[N-1:L]);
            r_neg2 <= r_neg1;
            r_sum  <= ((2*N)'(r_hh) << (2*L)) + (((2*N)'(r_lh) + (2*N)'(r_hl)) << L)
                      + (2*N)'(r_ll);
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? $signed(-r_sum) : $signed(r_sum);
        end
    end

    assign o_p = r_p;
endmodule

/* sv/swcc_sqrt.sv */
// Pipelined restoring integer square root, one root bit per stage.
// Carries a side payload with each item; depends on swcc_pkg.
module swcc_sqrt import swcc_pkg::*; #(
    parameter int RW = 50,
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [SBW-1:0]    i_side,
    output logic              o_valid,
    output logic [RW-1:0]     o_root,
    output logic [SBW-1:0]    o_side
);
    logic [2*RW-1:0] r_rem [RW];
    logic [RW-1:0]   r_root [RW];
    logic [SBW-1:0]  r_side [RW];
    logic            r_v [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [2*RW-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [SBW-1:0]  side_in;
        logic            v_in;
        logic [2*RW-1:0] trial;
        logic            fit;

        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
            assign v_in    = r_v[k-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign trial = ((2*RW)'(root_in) << (B + 1)) | ((2*RW)'(1) << (2 * B));
        assign fit   = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= fit ? rem_in - trial : rem_in;
                r_root[k] <= fit ? (root_in | (RW'(1) << B)) : root_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];
endmodule

/* sv/swcc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit QB bits; depends on swcc_pkg.
module swcc_div import swcc_pkg::*; #(
    parameter int AW = 50,
    parameter int QB = 24,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [AW+QB-1:0]  i_num,
    input  logic [AW-1:0]     i_den,
    input  logic [SBW-1:0]    i_side,
    output logic              o_valid,
    output logic [QB-1:0]     o_quo,
    output logic [SBW-1:0]    o_side
);
    localparam int QW = AW + QB;

    logic [QW-1:0]  r_rem [QB];
    logic [AW-1:0]  r_den [QB];
    logic [QB-1:0]  r_quo [QB];
    logic [SBW-1:0] r_side [QB];
    logic           r_v [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int B = QB - 1 - k;
        logic [QW-1:0]  rem_in;
        logic [AW-1:0]  den_in;
        logic [QB-1:0]  quo_in;
        logic [SBW-1:0] side_in;
        logic           v_in;
        logic [QW-1:0]  sub;
        logic           fit;

        if (k == 0) begin : g_first
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
            assign v_in    = r_v[k-1];
        end

        assign sub = QW'(den_in) << B;
        assign fit = rem_in >= sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= fit ? rem_in - sub : rem_in;
                r_den[k]  <= den_in;
                r_quo[k]  <= fit ? (quo_in | (QB'(1) << B)) : quo_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_quo   = r_quo[QB-1];
    assign o_side  = r_side[QB-1];
endmodule

/* test/swept_circle_collision_time_tb.sv */
// Testbench for the swept circle collision time block.
// Predicts hit and impact time per item and checks every result in order.
// Depends on swcc_pkg, swcc_if and the top level swept_circle_collision_time.
`timescale 1ns / 100ps

module swept_circle_collision_time_tb import swcc_pkg::*; ();

    localparam int CW = 24;
    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = 2 * 25 + 35 + 15;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        t_radius              first_radius;
        logic signed [CW-1:0] first_vx;
        logic signed [CW-1:0] first_vy;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        t_radius              second_radius;
        logic signed [CW-1:0] second_vx;
        logic signed [CW-1:0] second_vy;
    } t_pair;

    typedef struct packed {
        logic  hit;
        t_time impact_time;
    } t_impact;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TIME_W-1:0] i_cfg_wdata;

    swcc_in_if #(.COORD_WIDTH(CW)) pkt_if ();
    swcc_out_if res_if ();

    swept_circle_collision_time #(.COORD_WIDTH(CW), .TIME_FRAC_BITS(FRAC)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (pkt_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    t_impact impact_q[$];
    t_time   window;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_requests;
    int      hold_taken;
    int      hold_cycles;
    int      errors;
    int      items_sent;
    int      results_seen;
    int      hits_seen;
    int      quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_impact predict_impact(t_pair p, t_time win);
        logic signed [191:0] dx, dy, wx, wy, rs, a, h, c, d, s, cand;
        logic signed [191:0] tmax, tmin, scaled, limit, quot;
        t_impact r;
        r = '0;
        dx = p.second_x - p.first_x;
        dy = p.second_y - p.first_y;
        wx = p.second_vx - p.first_vx;
        wy = p.second_vy - p.first_vy;
        rs = {176'd0, p.first_radius} + {176'd0, p.second_radius};
        a = wx * wx + wy * wy;
        if (a == 0) return r;
        h = dx * wx + dy * wy;
        c = dx * dx + dy * dy - rs * rs;
        d = h * h - a * c;
        if (d < 0) return r;
        s = 0;
        for (int b = 72; b >= 0; b--) begin
            cand = s | (192'sd1 <<< b);
            if (cand * cand <= d) s = cand;
        end
        tmax = s - h;
        if (tmax < 0) return r;
        tmin = -h - s;
        scaled = tmin <<< FRAC;
        limit = {168'd0, win} * a;
        if (scaled > limit) return r;
        r.hit = 1'b1;
        if (tmin <= 0) return r;
        quot = scaled / a;
        r.impact_time = quot[TIME_W-1:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] rand_signed(int bits);
        int v;
        v = $urandom;
        return CW'(v >>> (32 - bits));
    endfunction

    // Two circles set on a closing course, with random noise on the aim.
    function automatic t_pair aimed_pair();
        t_pair p;
        int mag, k;
        logic signed [CW-1:0] ox, oy;
        mag = $urandom_range(20, 8);
        k = $urandom_range(3, 0);
        ox = rand_signed(mag);
        oy = rand_signed(mag);
        p.first_x = rand_signed(21);
        p.first_y = rand_signed(21);
        p.second_x = p.first_x + ox;
        p.second_y = p.first_y + oy;
        p.first_radius = t_radius'($urandom_range(0, (1 << (mag - 2)) - 1));
        p.second_radius = t_radius'($urandom_range(0, (1 << (mag - 2)) - 1));
        p.first_vx = rand_signed(18);
        p.first_vy = rand_signed(18);
        p.second_vx = p.first_vx - (ox >>> k) + rand_signed(mag - 3);
        p.second_vy = p.first_vy - (oy >>> k) + rand_signed(mag - 3);
        return p;
    endfunction

    function automatic t_pair any_pair();
        t_pair p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return p;
    endfunction

    task automatic send_pair(t_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            pkt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_if.valid <= 1'b1;
        {pkt_if.first_x, pkt_if.first_y, pkt_if.first_radius, pkt_if.first_vx,
         pkt_if.first_vy, pkt_if.second_x, pkt_if.second_y, pkt_if.second_radius,
         pkt_if.second_vx, pkt_if.second_vy} <= p;
        @(posedge i_clk);
        while (!pkt_if.ready) @(posedge i_clk);
        impact_q.push_back(predict_impact(p, window));
        items_sent++;
    endtask

    task automatic send_mix(int n);
        repeat (n) send_pair(($urandom_range(99) < 75) ? aimed_pair() : any_pair());
    endtask

    task automatic wait_drained();
        pkt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (impact_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(t_time v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        window = v;
    endtask

    task automatic report_mismatch(string what, t_impact got, t_impact want);
        errors++;
        $display("mismatch %s: hit %0b/%0b time %06h/%06h at %0t",
                 what, got.hit, want.hit, got.impact_time, want.impact_time, $time);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // head-on closing, contact at 0.8
        send_pair('{0, 0, 256, 0, 0, 2560, 0, 256, -2560, 0});
        // already overlapping, time clamps to zero
        send_pair('{0, 0, 256, 0, 0, 100, 0, 256, 50, 30});
        // overlapping but no relative motion
        send_pair('{0, 0, 256, 77, -9, 100, 0, 256, 77, -9});
        // parallel pass, negative discriminant
        send_pair('{0, 0, 10, 0, 0, -3000, 5000, 10, 2560, 0});
        // moving apart
        send_pair('{0, 0, 256, 0, 0, 2560, 0, 256, 2560, 0});
        // contact beyond the window
        send_pair('{0, 0, 256, 0, 0, 25600, 0, 256, -2560, 0});
        // touching at t = 0 and separating
        send_pair('{0, 0, 256, 0, 0, 512, 0, 256, 2560, 0});
        send_pair('{24'sh7fffff, 24'sh7fffff, 16'hffff, 24'sh7fffff, 24'sh7fffff,
                    24'sh7fffff, 24'sh7fffff, 16'hffff, 24'sh7fffff, 24'sh7fffff});
        send_pair('{-24'sh800000, -24'sh800000, 0, -24'sh800000, -24'sh800000,
                    24'sh7fffff, 24'sh7fffff, 0, 24'sh7fffff, 24'sh7fffff});
        send_pair('{24'sh7fffff, -24'sh800000, 16'hffff, 24'sh7fffff, -24'sh800000,
                    -24'sh800000, 24'sh7fffff, 16'hffff, -24'sh800000, 24'sh7fffff});
        send_pair('{-24'sh800000, 0, 16'hffff, 24'sh7fffff, 0,
                    24'sh7fffff, 0, 16'hffff, -24'sh800000, 0});
        send_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_pair('{0, 0, 0, 1, 0, 1, 0, 0, 0, 0});
        send_pair('{-24'sh7fff00, 0, 1, 24'sh7fffff, 0, 24'sh7fff00, 0, 1, -24'sh800000, 0});
        send_pair('{0, 0, 16'hffff, 0, 0, 24'sh7fffff, 0, 16'hffff, -1, 0});
    endtask

    task automatic test_window();
        t_time wins[5] = '{24'h000000, 24'hffffff, 24'h000001, 24'h040000, WINDOW_RESET};
        foreach (wins[i]) begin
            write_window(wins[i]);
            send_pair('{0, 0, 256, 0, 0, 2560, 0, 256, -2560, 0});
            send_pair('{0, 0, 256, 0, 0, 100, 0, 256, 50, 30});
            send_pair('{0, 0, 256, 0, 0, 25600, 0, 256, -2560, 0});
            send_mix(8);
        end
    endtask

    task automatic test_random();
        int idle[4] = '{0, 85, 0, 13};
        int stall[4] = '{0, 0, 85, 13};
        for (int ph = 0; ph < 4; ph++) begin
            write_window(($urandom_range(1)) ? WINDOW_RESET
                                            : t_time'($urandom_range(24'h080000, 1)));
            send_idle_pct = idle[ph];
            recv_stall_pct = stall[ph];
            send_mix(70);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_window(WINDOW_RESET);
        hold_requests++;
        send_mix(150);
        // let every result come back before offering more
        wait_drained();
        send_mix(20);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_taken != hold_requests) begin
            // start a long hold, counted down here
            hold_taken <= hold_requests;
            hold_cycles <= HOLD_LEN - 1;
            res_if.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_impact got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.hit = res_if.hit;
            got.impact_time = res_if.impact_time;
            results_seen++;
            if (got.hit) hits_seen++;
            if (impact_q.size() == 0) begin
                report_mismatch("unexpected item", got, '0);
            end else begin
                want = impact_q.pop_front();
                if (got.hit !== want.hit) report_mismatch("hit", got, want);
                else if (got.impact_time !== want.impact_time)
                    report_mismatch("impact_time", got, want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        hold_requests = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        window = WINDOW_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        pkt_if.valid = 1'b0;
        {pkt_if.first_x, pkt_if.first_y, pkt_if.first_radius, pkt_if.first_vx,
         pkt_if.first_vy, pkt_if.second_x, pkt_if.second_y, pkt_if.second_radius,
         pkt_if.second_vx, pkt_if.second_vy} = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_window();
        test_random();
        test_backpressure();
        wait_drained();
        $display("sent %0d circle pairs, checked %0d results (%0d hits)",
                 items_sent, results_seen, hits_seen);
        $display("covered window extremes, idle and stall mixes, long output hold");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* swept_circle_collision_time.f */
sv/swcc_pkg.sv
sv/swcc_if.sv
sv/swcc_wmul.sv
sv/swcc_sqrt.sv
sv/swcc_div.sv
sv/swept_circle_collision_time.sv
test/swept_circle_collision_time_tb.sv
